>>> rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
// Used by rau_ctrl, rau_dpath and rational_arithmetic_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rau_pkg;

  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned PORT_BITS     = 32;

  // Operation codes carried on kind_i
  typedef enum logic [2:0] {
    KIND_ADD  = 3'd0,
    KIND_SUB  = 3'd1,
    KIND_MUL  = 3'd2,
    KIND_DIV  = 3'd3,
    KIND_LT   = 3'd4,
    KIND_EQ   = 3'd5,
    KIND_NORM = 3'd6,
    KIND_NONE = 3'd7
  } kind_e;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_COMBINE,
    S_CHECK,
    S_TWOS,
    S_UODD,
    S_LOOP,
    S_DIVN,
    S_DIVD_INIT,
    S_DIVD,
    S_DIV_END,
    S_FIT,
    S_POST,
    S_OUT
  } state_e;

  // Datapath commands
  typedef enum logic [4:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_MUL0,
    CMD_MUL1,
    CMD_MUL2,
    CMD_COMBINE,
    CMD_PASS,
    CMD_GCD_INIT,
    CMD_GCD_TWOS,
    CMD_GCD_UODD,
    CMD_GCD_STEP,
    CMD_DIV_INIT_N,
    CMD_DIV_STEP,
    CMD_DIV_INIT_D,
    CMD_DIV_END,
    CMD_FIT,
    CMD_RESULT,
    CMD_SAVE_X,
    CMD_OUT
  } cmd_e;

  // Status from datapath to controller
  typedef struct packed {
    kind_e kind;
    logic  pass_b;
    logic  pass_thru;
    logic  both_even;
    logic  u_even;
    logic  v_zero;
    logic  div_last;
    logic  fit_ok;
  } status_t;

endpackage
`default_nettype wire

>>> rtl/rau_dpath.sv
// Datapath of the rational arithmetic unit: shared multiplier, binary GCD,
// restoring divider, fit shifter and result registers. Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_dpath
  import rau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire cmd_e                 cmd_i,
  output status_t                   status_o,
  input  wire logic [2:0]           kind_i,
  input  wire logic [PORT_BITS-1:0] a_num_i,
  input  wire logic [PORT_BITS-1:0] a_den_i,
  input  wire logic [PORT_BITS-1:0] b_num_i,
  input  wire logic [PORT_BITS-1:0] b_den_i,
  output logic [PORT_BITS-1:0]      r_num_o,
  output logic [PORT_BITS-1:0]      r_den_o,
  output logic                      truth_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned NW = 2 * WORD_BITS;
  localparam int unsigned CW = $clog2(NW);

  kind_e          kind_q;
  logic           pass_b_q;
  logic [W-1:0]   an_q, ad_q, bn_q, bd_q;
  logic [NW-1:0]  p1_q, p2_q;
  logic           neg_q;
  logic [NW-1:0]  mag_q, den_q;
  logic           truth_q;
  logic [NW-1:0]  u_q, v_q, g_q, rem_q, quo_q;
  logic [CW-1:0]  sh_q, cnt_q;
  logic [W-1:0]   res_num_q, res_den_q, x_num_q, x_den_q;
  logic [PORT_BITS-1:0] r_num_q, r_den_q;
  logic           r_truth_q;

  // Operand magnitudes
  logic [W-1:0] an_abs, bn_abs, xn, xd, xn_abs;
  assign an_abs = an_q[W-1] ? (~an_q + W'(1)) : an_q;
  assign bn_abs = bn_q[W-1] ? (~bn_q + W'(1)) : bn_q;
  assign xn     = pass_b_q ? bn_q : an_q;
  assign xd     = pass_b_q ? bd_q : ad_q;
  assign xn_abs = xn[W-1] ? (~xn + W'(1)) : xn;

  logic norm_kind;
  assign norm_kind = (kind_q == KIND_EQ) || (kind_q == KIND_NORM);

  // Select multiplier operands per phase
  logic [W-1:0]  mul_a, mul_b;
  logic [NW-1:0] prod;
  always_comb begin
    mul_a = an_abs;
    mul_b = bd_q;
    case (cmd_i)
      CMD_MUL0: begin
        if (norm_kind) begin
          mul_a = xn_abs;
          mul_b = W'(1);
        end else if (kind_q == KIND_MUL) begin
          mul_b = bn_abs;
        end
      end
      CMD_MUL1: begin
        mul_a = bn_abs;
        mul_b = ad_q;
      end
      CMD_MUL2: begin
        if (norm_kind) begin
          mul_a = xd;
          mul_b = W'(1);
        end else if (kind_q == KIND_DIV) begin
          mul_a = ad_q;
          mul_b = bn_abs;
        end else begin
          mul_a = ad_q;
          mul_b = bd_q;
        end
      end
      default: ;
    endcase
  end
  assign prod = NW'(mul_a) * NW'(mul_b);

  // Signed sum of the two cross terms
  logic          t1_neg, t2_neg, sum_neg;
  logic [NW-1:0] sum_mag;
  always_comb begin
    t1_neg = an_q[W-1];
    t2_neg = (kind_q == KIND_ADD) ? bn_q[W-1] : (!bn_q[W-1] && (bn_q != '0));
    if (t1_neg == t2_neg) begin
      sum_neg = t1_neg;
      sum_mag = p1_q + p2_q;
    end else if (p1_q >= p2_q) begin
      sum_neg = t1_neg;
      sum_mag = p1_q - p2_q;
    end else begin
      sum_neg = t2_neg;
      sum_mag = p2_q - p1_q;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
  end

  // GCD subtract step
  logic [NW:0]   gdiff;
  logic          u_gt;
  assign gdiff = {1'b0, u_q} - {1'b0, v_q};
  assign u_gt  = (u_q > v_q);

  // Restoring divider step
  logic [NW:0]   rem_sh, rem_sub;
  logic          q_bit;
  assign rem_sh  = {rem_q, quo_q[NW-1]};
  assign rem_sub = rem_sh - {1'b0, g_q};
  assign q_bit   = (rem_sh >= {1'b0, g_q});

  logic [W-1:0] mag_lo_neg;
  assign mag_lo_neg = neg_q ? (~mag_q[W-1:0] + W'(1)) : mag_q[W-1:0];

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        kind_q   <= kind_e'(kind_i);
        an_q     <= a_num_i[W-1:0];
        ad_q     <= a_den_i[W-1:0];
        bn_q     <= b_num_i[W-1:0];
        bd_q     <= b_den_i[W-1:0];
        pass_b_q <= 1'b0;
      end
      CMD_MUL0: p1_q  <= prod;
      CMD_MUL1: p2_q  <= prod;
      CMD_MUL2: den_q <= prod;
      CMD_COMBINE: begin
        truth_q <= sum_neg && (ad_q != '0) && (bd_q != '0);
        if (kind_q == KIND_MUL || kind_q == KIND_DIV) begin
          neg_q <= (an_q[W-1] ^ bn_q[W-1]) && (p1_q != '0);
          mag_q <= p1_q;
        end else if (norm_kind) begin
          neg_q <= xn[W-1];
          mag_q <= p1_q;
        end else begin
          neg_q <= sum_neg;
          mag_q <= sum_mag;
        end
      end
      CMD_PASS, CMD_RESULT: begin
        res_num_q <= mag_lo_neg;
        res_den_q <= den_q[W-1:0];
      end
      CMD_GCD_INIT: begin
        u_q  <= mag_q;
        v_q  <= den_q;
        sh_q <= '0;
      end
      CMD_GCD_TWOS: begin
        u_q  <= u_q >> 1;
        v_q  <= v_q >> 1;
        sh_q <= sh_q + CW'(1);
      end
      CMD_GCD_UODD: u_q <= u_q >> 1;
      CMD_GCD_STEP: begin
        if (!v_q[0]) begin
          v_q <= v_q >> 1;
        end else if (u_gt) begin
          u_q <= v_q;
          v_q <= gdiff[NW-1:0];
        end else begin
          v_q <= v_q - u_q;
        end
      end
      CMD_DIV_INIT_N: begin
        g_q   <= u_q << sh_q;
        rem_q <= '0;
        quo_q <= mag_q;
        cnt_q <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q <= q_bit ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
        quo_q <= {quo_q[NW-2:0], q_bit};
        cnt_q <= cnt_q + CW'(1);
      end
      CMD_DIV_INIT_D: begin
        mag_q <= quo_q;
        rem_q <= '0;
        quo_q <= den_q;
        cnt_q <= '0;
      end
      CMD_DIV_END: den_q <= quo_q;
      CMD_FIT: begin
        mag_q <= mag_q >> 1;
        den_q <= den_q >> 1;
      end
      CMD_SAVE_X: begin
        x_num_q  <= res_num_q;
        x_den_q  <= res_den_q;
        pass_b_q <= 1'b1;
      end
      CMD_OUT: begin
        r_num_q   <= '0;
        r_den_q   <= '0;
        r_truth_q <= 1'b0;
        case (kind_q)
          KIND_LT: r_truth_q <= truth_q;
          KIND_EQ: r_truth_q <= (x_num_q == res_num_q) && (x_den_q == res_den_q);
          KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV, KIND_NORM: begin
            r_num_q <= PORT_BITS'(res_num_q);
            r_den_q <= PORT_BITS'(res_den_q);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Status to controller
  always_comb begin
    status_o.kind      = kind_q;
    status_o.pass_b    = pass_b_q;
    status_o.pass_thru = (mag_q == '0) || (!neg_q && mag_q == NW'(1)) ||
                         (den_q == '0) || (den_q == NW'(1));
    status_o.both_even = !u_q[0] && !v_q[0];
    status_o.u_even    = !u_q[0];
    status_o.v_zero    = (v_q == '0);
    status_o.div_last  = (cnt_q == CW'(NW - 1));
    status_o.fit_ok    = (mag_q[NW-1:W-1] == '0) && (den_q[NW-1:W] == '0);
  end

  assign r_num_o = r_num_q;
  assign r_den_o = r_den_q;
  assign truth_o = r_truth_q;

endmodule
`default_nettype wire

>>> rtl/rau_ctrl.sv
// Controller of the rational arithmetic unit: sequences the datapath and
// runs both handshakes. Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire status_t status_i,
  output cmd_e         cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_IDLE;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_MUL0;
        end
      end
      S_MUL0: begin
        cmd_o   = CMD_MUL0;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        cmd_o   = CMD_MUL1;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        cmd_o   = CMD_MUL2;
        state_d = S_COMBINE;
      end
      S_COMBINE: begin
        cmd_o = CMD_COMBINE;
        if (status_i.kind == KIND_LT || status_i.kind == KIND_NONE) begin
          state_d = S_OUT;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.pass_thru) begin
          cmd_o   = CMD_PASS;
          state_d = S_POST;
        end else begin
          cmd_o   = CMD_GCD_INIT;
          state_d = S_TWOS;
        end
      end
      S_TWOS: begin
        if (status_i.both_even) cmd_o = CMD_GCD_TWOS;
        else state_d = S_UODD;
      end
      S_UODD: begin
        if (status_i.u_even) cmd_o = CMD_GCD_UODD;
        else state_d = S_LOOP;
      end
      S_LOOP: begin
        if (status_i.v_zero) begin
          cmd_o   = CMD_DIV_INIT_N;
          state_d = S_DIVN;
        end else begin
          cmd_o = CMD_GCD_STEP;
        end
      end
      S_DIVN: begin
        cmd_o = CMD_DIV_STEP;
        if (status_i.div_last) state_d = S_DIVD_INIT;
      end
      S_DIVD_INIT: begin
        cmd_o   = CMD_DIV_INIT_D;
        state_d = S_DIVD;
      end
      S_DIVD: begin
        cmd_o = CMD_DIV_STEP;
        if (status_i.div_last) state_d = S_DIV_END;
      end
      S_DIV_END: begin
        cmd_o   = CMD_DIV_END;
        state_d = S_FIT;
      end
      S_FIT: begin
        if (status_i.fit_ok) begin
          cmd_o   = CMD_RESULT;
          state_d = S_POST;
        end else begin
          cmd_o = CMD_FIT;
        end
      end
      S_POST: begin
        // Equal reduces a first, then b
        if (status_i.kind == KIND_EQ && !status_i.pass_b) begin
          cmd_o   = CMD_SAVE_X;
          state_d = S_MUL0;
        end else begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o       = CMD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: add, subtract, multiply, divide, less-than,
// equal and normalize over WORD_BITS-bit fractions (signed numerator,
// unsigned denominator, zero denominator is infinity).
// Input channel: kind_i and operands, accepted when in_valid_i is high
// and in_stall_o is low. Output channel: r_num_o, r_den_o, truth_o,
// taken when out_valid_o is high and out_stall_i is low. One result item
// per input item, in order.
// Items are handled one at a time; in_stall_o is high while one is in
// work, and the next item can be accepted in the cycle after the result
// is loaded. Less-than and the unused kind go from the products and the
// combine step straight to the output register; pass-through cases skip
// the GCD and the divisions. A full reduction runs the binary GCD (one
// shift or subtract a cycle), two restoring divisions of 2*WORD_BITS
// quotient bits each and up to WORD_BITS+1 fit shifts. Equal runs two
// reductions. A finished result waits in the output register while the
// next item is accepted; if that result is still stalled when the next
// one is done, the block holds it and keeps in_stall_o high. Reset
// empties the output register and returns the controller to idle.
// Depends on rau_pkg, rau_ctrl and rau_dpath.
`timescale 1ns / 1ps
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [2:0]           kind_i,
  input  wire logic [PORT_BITS-1:0] a_num_i,
  input  wire logic [PORT_BITS-1:0] a_den_i,
  input  wire logic [PORT_BITS-1:0] b_num_i,
  input  wire logic [PORT_BITS-1:0] b_den_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [PORT_BITS-1:0]      r_num_o,
  output logic [PORT_BITS-1:0]      r_den_o,
  output logic                      truth_o
);

  cmd_e    cmd;
  status_t status;

  // Sequencer
  rau_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Arithmetic datapath
  rau_dpath #(
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk_i    (clk_i),
    .cmd_i    (cmd),
    .status_o (status),
    .kind_i   (kind_i),
    .a_num_i  (a_num_i),
    .a_den_i  (a_den_i),
    .b_num_i  (b_num_i),
    .b_den_i  (b_den_i),
    .r_num_o  (r_num_o),
    .r_den_o  (r_den_o),
    .truth_o  (truth_o)
  );

endmodule
`default_nettype wire

>>> sim/rau_checker.sv
// Checker for the rational arithmetic unit: watches both channels, predicts
// each result item from the accepted input item and compares field by field.
// Depends on rau_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rau_checker
  import rau_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [2:0]  kind_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [31:0] b_den_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [31:0] r_num_i,
  input  wire logic [31:0] r_den_i,
  input  wire logic        truth_i,
  output int unsigned      pending_o,
  output int unsigned      errors_o
);

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
    logic        truth;
  } fraction_res_t;

  fraction_res_t expected_q[$];

  function automatic logic [63:0] gcd64(logic [63:0] u, logic [63:0] v);
    int unsigned sh;
    logic [63:0] t;
    sh = 0;
    if (u == 0) return v;
    if (v == 0) return u;
    while (((u | v) & 64'd1) == 0) begin
      u = u >> 1; v = v >> 1; sh++;
    end
    while (u[0] == 1'b0) u = u >> 1;
    while (v != 0) begin
      while (v[0] == 1'b0) v = v >> 1;
      if (u > v) begin
        t = u; u = v; v = t;
      end
      v = v - u;
    end
    return u << sh;
  endfunction

  // Reduce a sign and magnitude over a 64-bit denominator to word width
  function automatic logic [63:0] shrink(logic neg, logic [63:0] mag, logic [63:0] d);
    logic [63:0] g, rn, rd;
    if (mag == 0 || (!neg && mag == 1) || d == 0 || d == 1) begin
      rn = neg ? -mag : mag;
      return {rn[31:0], d[31:0]};
    end
    g = gcd64(mag, d);
    rn = mag / g;
    rd = d / g;
    while (rn > 64'h7FFF_FFFF || rd > 64'hFFFF_FFFF) begin
      rn = rn >> 1; rd = rd >> 1;
    end
    rn = neg ? -rn : rn;
    return {rn[31:0], rd[31:0]};
  endfunction

  function automatic logic [63:0] mag32(logic [31:0] x);
    logic [63:0] s;
    s = {{32{x[31]}}, x};
    return x[31] ? -s : s;
  endfunction

  function automatic fraction_res_t predict_fraction(kind_e k, logic [31:0] an,
      logic [31:0] ad, logic [31:0] bn, logic [31:0] bd);
    fraction_res_t r;
    logic n1, n2, nn;
    logic [63:0] m1, m2, mm, pr, xa, xb;
    longint sa, sb;
    r = '0;
    case (k)
      KIND_ADD, KIND_SUB: begin
        n1 = an[31];
        m1 = mag32(an) * {32'd0, bd};
        n2 = (k == KIND_SUB) ? ($signed(bn) > 0) : bn[31];
        m2 = mag32(bn) * {32'd0, ad};
        if (n1 == n2) begin
          nn = n1; mm = m1 + m2;
        end else if (m1 >= m2) begin
          nn = n1; mm = m1 - m2;
        end else begin
          nn = n2; mm = m2 - m1;
        end
        if (mm == 0) nn = 1'b0;
        pr = shrink(nn, mm, {32'd0, ad} * {32'd0, bd});
        {r.num, r.den} = pr;
      end
      KIND_MUL: begin
        mm = mag32(an) * mag32(bn);
        nn = (an[31] != bn[31]) && mm != 0;
        pr = shrink(nn, mm, {32'd0, ad} * {32'd0, bd});
        {r.num, r.den} = pr;
      end
      KIND_DIV: begin
        mm = mag32(an) * {32'd0, bd};
        nn = (an[31] != bn[31]) && mm != 0;
        pr = shrink(nn, mm, {32'd0, ad} * mag32(bn));
        {r.num, r.den} = pr;
      end
      KIND_LT: begin
        sa = longint'($signed(an)) * longint'({32'd0, bd});
        sb = longint'($signed(bn)) * longint'({32'd0, ad});
        if (ad != 0 && bd != 0) r.truth = sa < sb;
      end
      KIND_EQ: begin
        xa = shrink(an[31], mag32(an), {32'd0, ad});
        xb = shrink(bn[31], mag32(bn), {32'd0, bd});
        r.truth = xa == xb;
      end
      KIND_NORM: begin
        pr = shrink(an[31], mag32(an), {32'd0, ad});
        {r.num, r.den} = pr;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  // Record on input acceptance, compare on output acceptance
  always @(posedge clk_i or negedge rst_ni) begin
    fraction_res_t exp_r;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result item num=%h den=%h truth=%b",
                   $time, r_num_i, r_den_i, truth_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (exp_r.num !== r_num_i || exp_r.den !== r_den_i || exp_r.truth !== truth_i) begin
            $display("%0t: mismatch expected num=%h den=%h truth=%b actual num=%h den=%h truth=%b",
                     $time, exp_r.num, exp_r.den, exp_r.truth, r_num_i, r_den_i, truth_i);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_fraction(kind_e'(kind_i), a_num_i, a_den_i,
                                              b_num_i, b_den_i));
    end
  end

endmodule
`default_nettype wire

>>> sim/tb_rational_arithmetic_unit.sv
// Testbench top for the rational arithmetic unit: drives directed and random
// items with random idling on both sides and gives the verdict.
// Depends on rau_pkg, rational_arithmetic_unit and rau_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = KIND_ADD;
  logic [31:0] a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] r_num_o, r_den_o;
  logic        truth_o;
  int unsigned pending, errors;
  int unsigned cycles = 0;
  int unsigned send_idle = 0, recv_idle = 0;

  always #10 clk_i = ~clk_i;

  rational_arithmetic_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .kind_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .out_valid_o, .out_stall_i, .r_num_o, .r_den_o, .truth_o
  );

  rau_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .kind_i, .a_num_i,
    .a_den_i, .b_num_i, .b_den_i, .out_valid_i(out_valid_o), .out_stall_i,
    .r_num_i(r_num_o), .r_den_i(r_den_o), .truth_i(truth_o),
    .pending_o(pending), .errors_o(errors)
  );

  // Stall the output at random, changing on the falling edge
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle);

  // Hard stop on a hung block
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_rational_arithmetic_unit failed");
      $finish;
    end
  end

  // Offer one item and hold it until accepted; valid stays high afterwards
  task automatic send_item(kind_e k, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= k; a_num_i <= an; a_den_i <= ad; b_num_i <= bn; b_den_i <= bd;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'h7FFF_FFFF;
      5: return $urandom_range(100);
      6: return -$urandom_range(100);
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int unsigned count, int unsigned s_idle, int unsigned r_idle);
    logic [31:0] ad, bd, an;
    kind_e k;
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (count) begin
      k = kind_e'($urandom_range(7));
      an = pick_word();
      ad = pick_word();
      bd = pick_word();
      // Equal operands sometimes, to make the equal compare come out true
      if ($urandom_range(3) == 0)
        send_item(k, an, ad, an * 3, ad * 3);
      else
        send_item(k, an, ad, pick_word(), bd);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    // Directed: each kind, extremes, negative one, zero divisor, infinities
    send_item(KIND_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(KIND_ADD, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(KIND_SUB, 32'd1, 32'd3, 32'h8000_0000, 32'd1);
    send_item(KIND_SUB, 32'h7FFF_FFFF, 32'd7, 32'h7FFF_FFFF, 32'd7);
    send_item(KIND_MUL, 32'hFFFF_FFFF, 32'd6, 32'd4, 32'd9);
    send_item(KIND_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE);
    send_item(KIND_MUL, 32'd0, 32'd5, 32'd3, 32'd0);
    send_item(KIND_DIV, 32'd3, 32'd4, 32'hFFFF_FFFE, 32'd5);
    send_item(KIND_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send_item(KIND_DIV, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'hFFFF_FFFF);
    send_item(KIND_LT, 32'hFFFF_FFFF, 32'd2, 32'd1, 32'd2);
    send_item(KIND_LT, 32'd1, 32'd0, 32'd5, 32'd1);
    send_item(KIND_LT, 32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1);
    send_item(KIND_EQ, 32'd2, 32'd4, 32'd1, 32'd2);
    send_item(KIND_EQ, 32'd3, 32'd0, 32'd5, 32'd0);
    send_item(KIND_EQ, 32'd4, 32'd0, 32'd4, 32'd0);
    send_item(KIND_NORM, 32'hFFFF_FFFF, 32'd4, 32'd0, 32'd0);
    send_item(KIND_NORM, 32'd12, 32'd18, 32'd0, 32'd0);
    send_item(KIND_NORM, 32'd1, 32'd18, 32'd0, 32'd0);
    send_item(KIND_NONE, 32'd5, 32'd6, 32'd7, 32'd8);
    // Hold the sender until every result has come
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
    random_phase(300, 32, 50);
    random_phase(300, 50, 32);
    random_phase(300, 0, 0);
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_rational_arithmetic_unit passed");
    end else begin
      $display("tb_rational_arithmetic_unit failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
rtl/rau_pkg.sv
rtl/rau_dpath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
sim/rau_checker.sv
sim/tb_rational_arithmetic_unit.sv
